@@ rtl/core/srgbob_pkg.sv @@
package srgbob_pkg;

  typedef struct packed {
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [7:0] src_alpha;
    logic [7:0] dst_red;
    logic [7:0] dst_green;
    logic [7:0] dst_blue;
    logic [7:0] dst_alpha;
    logic       src_is_srgb;
    logic [1:0] opacity_mode;
    logic [8:0] mask_clip_alpha;
  } srgbob_in_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } srgbob_out_t;

  localparam logic [1:0] MODE_OPAQUE = 2'd0;
  localparam logic [1:0] MODE_MASKED = 2'd1;

  localparam logic [1:0] PICK_SRC   = 2'd0;
  localparam logic [1:0] PICK_DST   = 2'd1;
  localparam logic [1:0] PICK_BLEND = 2'd2;

  localparam logic [63:0] Q30_ONE = 64'd1 << 30;

  function automatic logic [63:0] q30_pow5(input logic [63:0] r);
    logic [63:0] p;
    p = (r * r) >> 30;
    p = (p * r) >> 30;
    p = (p * r) >> 30;
    p = (p * r) >> 30;
    return p;
  endfunction

  // elaboration-time table builders
  function automatic logic [63:0] srgb_decode_half(input logic [63:0] h, input int f);
    logic [63:0] a;
    logic [63:0] s;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] y;
    if (h <= 64'd20) begin
      return (((h * 64'd50) << f) + 64'd164730) / 64'd329460;
    end
    a = ((64'd500 * h + 64'd14025) << 30) / 64'd269025;
    s = (a * a) >> 30;
    lo = 64'd0;
    hi = Q30_ONE;
    for (int k = 0; k < 32; k++) begin
      if (lo < hi) begin
        mid = (lo + hi + 64'd1) >> 1;
        if (q30_pow5(mid) <= s) begin
          lo = mid;
        end else begin
          hi = mid - 64'd1;
        end
      end
    end
    y = (s * lo) >> 30;
    return (y + (64'd1 << (29 - f))) >> (30 - f);
  endfunction

  function automatic logic [63:0] byte_to_linear(input logic [63:0] c, input int f);
    return ((c << f) + 64'd127) / 64'd255;
  endfunction

endpackage

@@ rtl/core/srgbob_div_stage.sv @@
module srgbob_div_stage #(
  parameter int NW  = 35,
  parameter int DW  = 17,
  parameter int QW  = 17,
  parameter int BIT = 0,
  parameter int PW  = 112
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   en,
  input  logic                   v_i,
  input  logic [DW-1:0]          den_i,
  input  logic [2:0][NW-1:0]     rem_i,
  input  logic [2:0][QW-1:0]     q_i,
  input  logic [PW-1:0]          pass_i,
  output logic                   v_o,
  output logic [DW-1:0]          den_o,
  output logic [2:0][NW-1:0]     rem_o,
  output logic [2:0][QW-1:0]     q_o,
  output logic [PW-1:0]          pass_o
);

  logic                v_r;
  logic [DW-1:0]       den_r;
  logic [2:0][NW-1:0]  rem_r;
  logic [2:0][NW-1:0]  rem_nxt;
  logic [2:0][QW-1:0]  q_r;
  logic [2:0][QW-1:0]  q_nxt;
  logic [PW-1:0]       pass_r;
  logic [NW-1:0]       dsh;

  assign dsh = NW'(den_i) << BIT;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      q_nxt[c] = q_i[c];
      if (rem_i[c] >= dsh) begin
        rem_nxt[c]    = rem_i[c] - dsh;
        q_nxt[c][BIT] = 1'b1;
      end else begin
        rem_nxt[c] = rem_i[c];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= v_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r  <= den_i;
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
      pass_r <= pass_i;
    end
  end

  assign v_o    = v_r;
  assign den_o  = den_r;
  assign rem_o  = rem_r;
  assign q_o    = q_r;
  assign pass_o = pass_r;

endmodule

@@ rtl/core/srgb_alpha_over_blend_top.sv @@
// sRGB straight-alpha over blend, one pixel per beat.
// Input channel in_valid/in_ready/in_data carries source and destination
// pixels plus per-pixel mode fields; output channel out_valid/out_ready/
// out_data carries the sRGB-encoded result and linear alpha byte.
// Throughput: one pixel per clock while out_ready stays high, no state between pixels.
// Pipeline: 4 decode/multiply stages, LINEAR_FRAC_BITS+1 restoring divider stages
// and 8 binary-search encode stages lie between accept and out_valid. The divider
// chain, one quotient bit per stage, sets the depth.
// Each stage advances when it is empty or the stage after it advances, so
// when the receiver holds out_ready low, results stay put and the pipeline
// keeps accepting until its bubbles are filled; nothing is lost or repeated.
// in_ready may follow out_ready combinationally through that chain.
// Reset (rst_n low, synchronous) empties all stages; decode and encode
// tables are constants and need no fill time.
module srgb_alpha_over_blend_top #(
  parameter int LINEAR_FRAC_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  srgbob_pkg::srgbob_in_t   in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output srgbob_pkg::srgbob_out_t  out_data
);

  localparam int F  = LINEAR_FRAC_BITS;
  localparam int LW = F + 1;
  localparam int PL = 2 * LW;
  localparam int NW = 2 * LW + 1;
  localparam int QW = LW;
  localparam int PW = 2 + 6 * LW + 8;
  localparam int NS = 12 + QW;
  localparam logic [LW-1:0] ONE   = {1'b1, {F{1'b0}}};
  localparam logic [PL-1:0] HALFP = PL'(1) << (F - 1);
  localparam logic [LW+7:0] HALFA = (LW + 8)'(1) << (F - 1);

  logic [LW-1:0] dec_rom  [256];
  logic [LW-1:0] lin_rom  [256];
  logic [LW-1:0] edge_rom [255];

  for (genvar i = 0; i < 256; i++) begin : g_rom
    localparam logic [LW-1:0] DV = LW'(srgbob_pkg::srgb_decode_half(64'(2 * i), F));
    localparam logic [LW-1:0] LV = LW'(srgbob_pkg::byte_to_linear(64'(i), F));
    assign dec_rom[i] = DV;
    assign lin_rom[i] = LV;
  end
  for (genvar i = 0; i < 255; i++) begin : g_edge
    localparam logic [LW-1:0] EV = LW'(srgbob_pkg::srgb_decode_half(64'(2 * i + 1), F));
    assign edge_rom[i] = EV;
  end

  logic [NS-1:0] vv;
  logic [NS-1:0] en;

  always_comb begin
    en[NS-1] = !vv[NS-1] || out_ready;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vv[k] || en[k+1];
    end
  end

  assign in_ready = en[0];

  // stage 1: decode
  logic                v1_r;
  logic [1:0]          pick1_r;
  logic [2:0][LW-1:0]  sc1_r;
  logic [2:0][LW-1:0]  dc1_r;
  logic [LW-1:0]       sa1_r;
  logic [LW-1:0]       da1_r;
  logic [1:0]          pick_nxt;
  logic [2:0][7:0]     sbytes;
  logic [2:0][7:0]     dbytes;

  assign sbytes = {in_data.src_blue, in_data.src_green, in_data.src_red};
  assign dbytes = {in_data.dst_blue, in_data.dst_green, in_data.dst_red};

  always_comb begin
    case (in_data.opacity_mode)
      srgbob_pkg::MODE_OPAQUE: pick_nxt = srgbob_pkg::PICK_SRC;
      srgbob_pkg::MODE_MASKED: begin
        pick_nxt = ({1'b0, in_data.src_alpha} < in_data.mask_clip_alpha) ?
                   srgbob_pkg::PICK_DST : srgbob_pkg::PICK_SRC;
      end
      default: begin
        if (in_data.src_alpha == 8'd0) begin
          pick_nxt = srgbob_pkg::PICK_DST;
        end else if (in_data.src_alpha == 8'd255) begin
          pick_nxt = srgbob_pkg::PICK_SRC;
        end else begin
          pick_nxt = srgbob_pkg::PICK_BLEND;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en[0]) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pick1_r <= pick_nxt;
      for (int c = 0; c < 3; c++) begin
        sc1_r[c] <= in_data.src_is_srgb ? dec_rom[sbytes[c]] : lin_rom[sbytes[c]];
        dc1_r[c] <= dec_rom[dbytes[c]];
      end
      sa1_r <= lin_rom[in_data.src_alpha];
      da1_r <= lin_rom[in_data.dst_alpha];
    end
  end

  // stage 2: source and coverage products
  logic                v2_r;
  logic [1:0]          pick2_r;
  logic [2:0][LW-1:0]  sc2_r;
  logic [2:0][LW-1:0]  dc2_r;
  logic [LW-1:0]       sa2_r;
  logic [LW-1:0]       da2_r;
  logic [2:0][PL-1:0]  psa2_r;
  logic [PL-1:0]       pt2_r;
  logic [LW-1:0]       one_m_sa;

  assign one_m_sa = ONE - sa1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en[1]) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      pick2_r <= pick1_r;
      sc2_r   <= sc1_r;
      dc2_r   <= dc1_r;
      sa2_r   <= sa1_r;
      da2_r   <= da1_r;
      for (int c = 0; c < 3; c++) begin
        psa2_r[c] <= PL'(sc1_r[c]) * PL'(sa1_r);
      end
      pt2_r <= PL'(da1_r) * PL'(one_m_sa);
    end
  end

  // stage 3: T, output alpha, destination products
  logic                v3_r;
  logic [1:0]          pick3_r;
  logic [2:0][LW-1:0]  sc3_r;
  logic [2:0][LW-1:0]  dc3_r;
  logic [2:0][PL-1:0]  psa3_r;
  logic [2:0][PL-1:0]  pdt3_r;
  logic [LW-1:0]       oa3_r;
  logic [PL-1:0]       tsum;
  logic [LW-1:0]       tval;
  logic [LW-1:0]       oa_nxt;

  assign tsum = pt2_r + HALFP;
  assign tval = tsum[F +: LW];

  always_comb begin
    case (pick2_r)
      srgbob_pkg::PICK_SRC: oa_nxt = ONE;
      srgbob_pkg::PICK_DST: oa_nxt = da2_r;
      default:              oa_nxt = sa2_r + tval;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en[2]) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      pick3_r <= pick2_r;
      sc3_r   <= sc2_r;
      dc3_r   <= dc2_r;
      psa3_r  <= psa2_r;
      oa3_r   <= oa_nxt;
      for (int c = 0; c < 3; c++) begin
        pdt3_r[c] <= PL'(dc2_r[c]) * PL'(tval);
      end
    end
  end

  // stage 4: numerator sums, alpha byte
  logic                v4_r;
  logic [1:0]          pick4_r;
  logic [2:0][LW-1:0]  sc4_r;
  logic [2:0][LW-1:0]  dc4_r;
  logic [2:0][NW-1:0]  num4_r;
  logic [LW-1:0]       oa4_r;
  logic [7:0]          ab4_r;
  logic [LW+7:0]       aprod;
  logic [8:0]          ahi;

  assign aprod = ((LW + 8)'(oa3_r) << 8) - (LW + 8)'(oa3_r) + HALFA;
  assign ahi   = aprod[F +: 9];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (en[3]) begin
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      pick4_r <= pick3_r;
      sc4_r   <= sc3_r;
      dc4_r   <= dc3_r;
      oa4_r   <= oa3_r;
      ab4_r   <= ahi[8] ? 8'hFF : ahi[7:0];
      for (int c = 0; c < 3; c++) begin
        num4_r[c] <= NW'(psa3_r[c]) + NW'(pdt3_r[c]) + NW'(oa3_r >> 1);
      end
    end
  end

  // restoring divider, one quotient bit per stage
  logic                dv    [QW+1];
  logic [LW-1:0]       dden  [QW+1];
  logic [2:0][NW-1:0]  drem  [QW+1];
  logic [2:0][QW-1:0]  dq    [QW+1];
  logic [PW-1:0]       dpass [QW+1];

  assign dv[0]    = v4_r;
  assign dden[0]  = oa4_r;
  assign drem[0]  = num4_r;
  assign dq[0]    = '0;
  assign dpass[0] = {pick4_r, sc4_r, dc4_r, ab4_r};

  for (genvar j = 0; j < QW; j++) begin : g_div
    srgbob_div_stage #(
      .NW  (NW),
      .DW  (LW),
      .QW  (QW),
      .BIT (QW - 1 - j),
      .PW  (PW)
    ) u_stage (
      .clk    (clk),
      .rst_n  (rst_n),
      .en     (en[4+j]),
      .v_i    (dv[j]),
      .den_i  (dden[j]),
      .rem_i  (drem[j]),
      .q_i    (dq[j]),
      .pass_i (dpass[j]),
      .v_o    (dv[j+1]),
      .den_o  (dden[j+1]),
      .rem_o  (drem[j+1]),
      .q_o    (dq[j+1]),
      .pass_o (dpass[j+1])
    );
  end

  // result select
  logic [1:0]          rpick;
  logic [2:0][LW-1:0]  rsc;
  logic [2:0][LW-1:0]  rdc;
  logic [7:0]          rab;
  logic [2:0][LW-1:0]  rlin;

  assign rpick = dpass[QW][PW-1 -: 2];
  assign rsc   = dpass[QW][PW-3 -: 3*LW];
  assign rdc   = dpass[QW][8 +: 3*LW];
  assign rab   = dpass[QW][7:0];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      case (rpick)
        srgbob_pkg::PICK_SRC: rlin[c] = rsc[c];
        srgbob_pkg::PICK_DST: rlin[c] = rdc[c];
        default:              rlin[c] = (dq[QW][c] > ONE) ? ONE : dq[QW][c];
      endcase
    end
  end

  // sRGB encode: binary search over the edge table
  logic                ev  [9];
  logic [2:0][7:0]     enn [9];
  logic [2:0][LW-1:0]  el  [9];
  logic [7:0]          eab [9];

  assign ev[0]  = dv[QW];
  assign enn[0] = '0;
  assign el[0]  = rlin;
  assign eab[0] = rab;

  for (genvar k = 0; k < 8; k++) begin : g_enc
    logic                v_r;
    logic [2:0][7:0]     n_r;
    logic [2:0][7:0]     n_nxt;
    logic [2:0][LW-1:0]  l_r;
    logic [7:0]          ab_r;

    always_comb begin
      logic [7:0] cand;
      for (int c = 0; c < 3; c++) begin
        cand = enn[k][c] | (8'd1 << (7 - k));
        n_nxt[c] = (edge_rom[cand - 8'd1] <= el[k][c]) ? cand : enn[k][c];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r <= 1'b0;
      end else if (en[4+QW+k]) begin
        v_r <= ev[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en[4+QW+k]) begin
        n_r  <= n_nxt;
        l_r  <= el[k];
        ab_r <= eab[k];
      end
    end

    assign ev[k+1]  = v_r;
    assign enn[k+1] = n_r;
    assign el[k+1]  = l_r;
    assign eab[k+1] = ab_r;
  end

  always_comb begin
    vv[0] = v1_r;
    vv[1] = v2_r;
    vv[2] = v3_r;
    vv[3] = v4_r;
    for (int j = 0; j < QW; j++) begin
      vv[4+j] = dv[j+1];
    end
    for (int k = 0; k < 8; k++) begin
      vv[4+QW+k] = ev[k+1];
    end
  end

  assign out_valid          = ev[8];
  assign out_data.out_red   = enn[8][0];
  assign out_data.out_green = enn[8][1];
  assign out_data.out_blue  = enn[8][2];
  assign out_data.out_alpha = eab[8];

endmodule

@@ bench/srgb_alpha_over_blend_top_tb.sv @@
`timescale 1ns / 100ps

module srgb_alpha_over_blend_top_tb;

  localparam int FRAC = 16;
  localparam logic [63:0] ONE = 64'd1 << FRAC;
  localparam logic [1:0] MODE_TRANSLUCENT = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;
  localparam int LATENCY = FRAC + 13;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  srgbob_pkg::srgbob_in_t in_data;
  logic out_valid;
  logic out_ready;
  srgbob_pkg::srgbob_out_t out_data;

  srgb_alpha_over_blend_top #(.LINEAR_FRAC_BITS(FRAC)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  logic [63:0] lin_of_code[256];
  logic [63:0] code_edge[255];

  srgbob_pkg::srgbob_in_t pixel_queue[$];
  srgbob_pkg::srgbob_out_t blend_expected[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int quiet_cycles = 0;

  // decode of half-step h (value h/510) to linear fixed point
  function automatic logic [63:0] half_to_lin(input logic [63:0] h);
    logic [63:0] a, s, lo, hi, mid, p, y;
    if (h <= 64'd20) return (((h * 64'd50) << FRAC) + 64'd164730) / 64'd329460;
    a = ((64'd500 * h + 64'd14025) << 30) / 64'd269025;
    s = (a * a) >> 30;
    lo = 0;
    hi = 64'd1 << 30;
    while (lo < hi) begin
      mid = (lo + hi + 64'd1) >> 1;
      p = (mid * mid) >> 30;
      p = (p * mid) >> 30;
      p = (p * mid) >> 30;
      p = (p * mid) >> 30;
      if (p <= s) lo = mid;
      else hi = mid - 64'd1;
    end
    y = (s * lo) >> 30;
    return (y + (64'd1 << (29 - FRAC))) >> (30 - FRAC);
  endfunction

  function automatic logic [63:0] unit_lin(input logic [7:0] c);
    return ((64'(c) << FRAC) + 64'd127) / 64'd255;
  endfunction

  function automatic logic [7:0] lin_to_code(input logic [63:0] l);
    int n;
    n = 0;
    for (int b = 0; b < 255; b++) if (l >= code_edge[b]) n++;
    return 8'(n);
  endfunction

  function automatic srgbob_pkg::srgbob_out_t blend_pixel(input srgbob_pkg::srgbob_in_t px);
    logic [63:0] sc[3], dc[3], res[3];
    logic [63:0] sa, da, oa, t, v;
    logic [1:0] pick;
    logic [7:0] sb[3], db[3];
    srgbob_pkg::srgbob_out_t r;
    sb = '{px.src_red, px.src_green, px.src_blue};
    db = '{px.dst_red, px.dst_green, px.dst_blue};
    for (int i = 0; i < 3; i++) begin
      sc[i] = px.src_is_srgb ? lin_of_code[sb[i]] : unit_lin(sb[i]);
      dc[i] = lin_of_code[db[i]];
    end
    sa = unit_lin(px.src_alpha);
    da = unit_lin(px.dst_alpha);
    if (px.opacity_mode == srgbob_pkg::MODE_OPAQUE) pick = srgbob_pkg::PICK_SRC;
    else if (px.opacity_mode == srgbob_pkg::MODE_MASKED)
      pick = ({1'b0, px.src_alpha} < px.mask_clip_alpha) ?
             srgbob_pkg::PICK_DST : srgbob_pkg::PICK_SRC;
    else if (px.src_alpha == 8'd0) pick = srgbob_pkg::PICK_DST;
    else if (px.src_alpha == 8'd255) pick = srgbob_pkg::PICK_SRC;
    else pick = srgbob_pkg::PICK_BLEND;
    if (pick == srgbob_pkg::PICK_SRC) begin
      res = sc;
      oa = ONE;
    end else if (pick == srgbob_pkg::PICK_DST) begin
      res = dc;
      oa = da;
    end else begin
      t = (da * (ONE - sa) + (ONE >> 1)) >> FRAC;
      oa = sa + t;
      if (oa == 0) return '0;
      for (int i = 0; i < 3; i++) begin
        v = (sc[i] * sa + dc[i] * t + (oa >> 1)) / oa;
        res[i] = (v > ONE) ? ONE : v;
      end
    end
    r.out_red = lin_to_code(res[0]);
    r.out_green = lin_to_code(res[1]);
    r.out_blue = lin_to_code(res[2]);
    v = (oa * 64'd255 + (ONE >> 1)) >> FRAC;
    r.out_alpha = (v > 64'd255) ? 8'd255 : v[7:0];
    return r;
  endfunction

  function automatic srgbob_pkg::srgbob_in_t random_pixel();
    srgbob_pkg::srgbob_in_t px;
    logic [95:0] raw;
    raw = {$urandom, $urandom, $urandom};
    px = raw[$bits(srgbob_pkg::srgbob_in_t)-1:0];
    case ($urandom_range(0, 5))
      0: px.src_alpha = 8'd0;
      1: px.src_alpha = 8'd255;
      default: ;
    endcase
    if ($urandom_range(0, 3) == 0) px.mask_clip_alpha = 9'($urandom_range(0, 256));
    return px;
  endfunction

  function automatic srgbob_pkg::srgbob_in_t make_pixel(input logic [7:0] c,
                                                        input logic [7:0] sa,
                                                        input logic [7:0] da,
                                                        input logic srgb,
                                                        input logic [1:0] mode,
                                                        input logic [8:0] clip);
    srgbob_pkg::srgbob_in_t px;
    px.src_red = c;
    px.src_green = ~c;
    px.src_blue = c ^ 8'h5a;
    px.src_alpha = sa;
    px.dst_red = ~c;
    px.dst_green = c;
    px.dst_blue = c ^ 8'ha5;
    px.dst_alpha = da;
    px.src_is_srgb = srgb;
    px.opacity_mode = mode;
    px.mask_clip_alpha = clip;
    return px;
  endfunction

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else if (!in_valid || in_ready) begin
      if (pixel_queue.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pixel_queue.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (in_valid && in_ready && rst_n) blend_expected.push_back(blend_pixel(in_data));
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    srgbob_pkg::srgbob_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (blend_expected.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", out_data);
      end else begin
        want = blend_expected.pop_front();
        if (want.out_red !== out_data.out_red || want.out_green !== out_data.out_green ||
            want.out_blue !== out_data.out_blue || want.out_alpha !== out_data.out_alpha) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected r%0d g%0d b%0d a%0d, got r%0d g%0d b%0d a%0d",
                     want.out_red, want.out_green, want.out_blue, want.out_alpha,
                     out_data.out_red, out_data.out_green, out_data.out_blue,
                     out_data.out_alpha);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic run_phase(input int idle, input int stall, input int count);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < count; i++) pixel_queue.push_back(random_pixel());
    while (pixel_queue.size() > 0 || in_valid) @(posedge clk);
  endtask

  initial begin
    for (int c = 0; c < 256; c++) lin_of_code[c] = half_to_lin(64'(2 * c));
    for (int b = 0; b < 255; b++) code_edge[b] = half_to_lin(64'(2 * b + 1));
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    pixel_queue.push_back(make_pixel(8'd0, 8'd0, 8'd0, 1'b1, srgbob_pkg::MODE_OPAQUE, 9'd0));
    pixel_queue.push_back(make_pixel(8'd255, 8'd255, 8'd255, 1'b0, srgbob_pkg::MODE_OPAQUE,
                                     9'd256));
    pixel_queue.push_back(make_pixel(8'd10, 8'd99, 8'd30, 1'b1, srgbob_pkg::MODE_MASKED,
                                     9'd100));
    pixel_queue.push_back(make_pixel(8'd77, 8'd100, 8'd30, 1'b0, srgbob_pkg::MODE_MASKED,
                                     9'd100));
    pixel_queue.push_back(make_pixel(8'd200, 8'd255, 8'd200, 1'b1, srgbob_pkg::MODE_MASKED,
                                     9'd256));
    pixel_queue.push_back(make_pixel(8'd5, 8'd255, 8'd0, 1'b0, srgbob_pkg::MODE_MASKED,
                                     9'd255));
    pixel_queue.push_back(make_pixel(8'd9, 8'd0, 8'd0, 1'b1, srgbob_pkg::MODE_MASKED, 9'd0));
    pixel_queue.push_back(make_pixel(8'd40, 8'd0, 8'd128, 1'b1, MODE_TRANSLUCENT, 9'd0));
    pixel_queue.push_back(make_pixel(8'd41, 8'd255, 8'd128, 1'b0, MODE_TRANSLUCENT, 9'd0));
    pixel_queue.push_back(make_pixel(8'd128, 8'd1, 8'd0, 1'b1, MODE_TRANSLUCENT, 9'd0));
    pixel_queue.push_back(make_pixel(8'd128, 8'd254, 8'd255, 1'b0, MODE_TRANSLUCENT, 9'd0));
    pixel_queue.push_back(make_pixel(8'd3, 8'd128, 8'd255, 1'b1, MODE_TRANSLUCENT, 9'd0));
    pixel_queue.push_back(make_pixel(8'd250, 8'd64, 8'd0, 1'b0, MODE_SPARE, 9'd511));
    pixel_queue.push_back(make_pixel(8'd0, 8'd0, 8'd0, 1'b1, MODE_SPARE, 9'd0));
    pixel_queue.push_back(make_pixel(8'd255, 8'd200, 8'd255, 1'b1, MODE_TRANSLUCENT, 9'd0));
    pixel_queue.push_back(make_pixel(8'd11, 8'd50, 8'd255, 1'b0, srgbob_pkg::MODE_MASKED,
                                     9'd511));
    run_phase(0, 0, 0);

    run_phase(0, 0, 400);
    run_phase(85, 0, 250);
    run_phase(0, 85, 250);
    // long receiver hold while the sender keeps offering, to back up the pipe
    hold_cycles = 3 * LATENCY;
    run_phase(0, 0, 200);
    run_phase(11, 11, 400);

    while (blend_expected.size() > 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
    if (mismatches == 0 && blend_expected.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
